// ===== rtl/fat_table_cluster_bitmap_core_assert.svh =====
// Assertion macros used by the port-level checker file
`ifndef FAT_TABLE_CLUSTER_BITMAP_CORE_ASSERT_SVH
`define FAT_TABLE_CLUSTER_BITMAP_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define FTCB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FTCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ftcb_pkg.sv =====
// Types and constants of the FAT cluster usage bitmap core
package ftcb_pkg;

  // one table byte per beat
  typedef struct packed {
    logic [7:0] table_byte;
    logic       first_byte;
  } in_beat_t;

  // one map byte per beat
  typedef struct packed {
    logic [7:0]  map_byte;
    logic        map_last;
    logic [15:0] used_count;
  } out_beat_t;

  // position of a byte inside an entry (FAT16) or entry pair (FAT12)
  typedef enum logic [1:0] {
    PH_LO  = 2'd0,
    PH_MID = 2'd1,
    PH_HI  = 2'd2
  } phase_t;

  localparam logic [15:0] BAD16 = 16'hFFF7;
  localparam logic [11:0] BAD12 = 12'hFF7;

  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_TYPE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 1'd1;

endpackage

// ===== rtl/fat_table_cluster_bitmap_core.sv =====
// FAT cluster usage bitmap core: top level
// Input channel (in_valid / in_stall / in_data): raw FAT bytes in disk order,
// one per beat; first_byte marks byte zero and restarts the scan at any time.
// Output channel (out_valid / out_stall / out_data): one map byte per eight
// data clusters, lowest cluster in bit 0, with the running used count. The
// byte that holds the final cluster carries map_last and ends the scan; bytes
// after it are dropped until the next first_byte.
// Config port (cfg_we / cfg_index / cfg_wdata): index 0 fat_type (0 = FAT12,
// 1 = FAT16), index 1 cluster_count. Write only while the block is idle.
// Throughput: one byte per cycle while the output is not stalled. The input
// register feeds the unpack, classify and pack logic, which loads the output
// register with the map byte when the table byte that completes it advances.
// Stall: a stalled output beat holds; the input register keeps taking bytes
// until it is also full, then in_stall rises in the same cycle.
// Reset (rst_n low, synchronous): both channels empty, scan idle,
// fat_type = FAT16, cluster_count = 0.
module fat_table_cluster_bitmap_core
  import ftcb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // config
  logic        fat16_r;
  logic [15:0] ccount_r;

  // input register
  logic     s1_valid_r;
  in_beat_t s1_data_r;

  // scan state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  part_r, part_nxt;
  logic [16:0] idx_r, idx_nxt;
  logic [2:0]  bitp_r, bitp_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [15:0] used_r, used_nxt;
  logic        done_r, done_nxt;

  // output register
  logic      out_valid_r;
  out_beat_t out_data_r;

  logic        advance;
  logic        in_accept;
  logic        take;
  logic [15:0] entry;
  logic        emit;
  out_beat_t   res;

  // effective state after a possible restart
  phase_t      eff_phase;
  logic [7:0]  eff_part;
  logic [16:0] eff_idx;
  logic [2:0]  eff_bitp;
  logic [7:0]  eff_acc;
  logic [15:0] eff_used;
  logic        eff_done;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (s1_data_r.first_byte) begin
      eff_phase = PH_LO;
      eff_part  = '0;
      eff_idx   = '0;
      eff_bitp  = '0;
      eff_acc   = '0;
      eff_used  = '0;
      eff_done  = (ccount_r == 16'd0);
    end else begin
      eff_phase = phase_r;
      eff_part  = part_r;
      eff_idx   = idx_r;
      eff_bitp  = bitp_r;
      eff_acc   = acc_r;
      eff_used  = used_r;
      eff_done  = done_r;
    end
  end

  // next state: byte phase, partial entry and the completed entry
  always_comb begin
    phase_nxt = eff_phase;
    part_nxt  = eff_part;
    take      = 1'b0;
    entry     = '0;
    if (!eff_done) begin
      if (eff_phase == PH_LO) begin
        part_nxt  = s1_data_r.table_byte;
        phase_nxt = PH_MID;
      end else if (fat16_r) begin
        // any later phase is the high byte
        phase_nxt = PH_LO;
        take      = 1'b1;
        entry     = {s1_data_r.table_byte, eff_part};
      end else begin
        case (eff_phase)
          PH_MID: begin
            phase_nxt = PH_HI;
            part_nxt  = {4'd0, s1_data_r.table_byte[7:4]};
            take      = 1'b1;
            entry     = {4'd0, s1_data_r.table_byte[3:0], eff_part};
          end
          default: begin
            phase_nxt = PH_LO;
            part_nxt  = '0;
            take      = 1'b1;
            entry     = {4'd0, s1_data_r.table_byte, eff_part[3:0]};
          end
        endcase
      end
    end
  end

  // classify and pack
  always_comb begin
    logic reserved;
    logic used;
    logic last;
    idx_nxt  = eff_idx;
    bitp_nxt = eff_bitp;
    acc_nxt  = eff_acc;
    used_nxt = eff_used;
    done_nxt = eff_done;
    emit     = 1'b0;
    res      = '0;
    reserved = (eff_idx[16:1] == 16'd0);
    used     = (entry != 16'd0) && (entry != (fat16_r ? BAD16 : {4'd0, BAD12}));
    last     = eff_idx >= ({1'b0, ccount_r} + 17'd1);
    if (take) begin
      idx_nxt = eff_idx + 17'd1;
      if (!reserved) begin
        if (used) begin
          acc_nxt  = eff_acc | (8'd1 << eff_bitp);
          used_nxt = eff_used + 16'd1;
        end
        bitp_nxt = eff_bitp + 3'd1;
        if ((eff_bitp == 3'd7) || last) begin
          emit           = 1'b1;
          res.map_byte   = acc_nxt;
          res.map_last   = last;
          res.used_count = used_nxt;
          acc_nxt        = '0;
          bitp_nxt       = '0;
          done_nxt       = eff_done | last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat16_r     <= 1'b1;
      ccount_r    <= '0;
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_LO;
      part_r      <= '0;
      idx_r       <= '0;
      bitp_r      <= '0;
      acc_r       <= '0;
      used_r      <= '0;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FAT_TYPE:      fat16_r  <= cfg_wdata[0];
          CFG_CLUSTER_COUNT: ccount_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        phase_r <= phase_nxt;
        part_r  <= part_nxt;
        idx_r   <= idx_nxt;
        bitp_r  <= bitp_nxt;
        acc_r   <= acc_nxt;
        used_r  <= used_nxt;
        done_r  <= done_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (advance && emit) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== rtl/ftcb_checker.sv =====
// Port-level checker for the FAT cluster usage bitmap core, with its bind
`include "fat_table_cluster_bitmap_core_assert.svh"
module ftcb_checker
  import ftcb_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_beat_t            out_data
);

  // a stalled map beat holds
  `FTCB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "map beat dropped or changed while stalled")

  // input backs up only behind a stalled output
  `FTCB_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without output backpressure")

  // a new map beat follows a table byte taken into the input register
  `FTCB_ASSERT_SAME(a_out_source, $rose(out_valid), $past(in_valid && !in_stall, 2), "map beat without a table byte")

endmodule

bind fat_table_cluster_bitmap_core ftcb_checker u_ftcb_checker (.*);
